@@ src/bate_pkg.sv @@
package bate_pkg;

    localparam int Depth = 64;
    localparam int AddrW = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);

    typedef enum logic [3:0] {
        OP_APPEND     = 4'd0,
        OP_PREPEND    = 4'd1,
        OP_SORTED_INS = 4'd2,
        OP_APPEND_UNQ = 4'd3,
        OP_REMOVE_AT  = 4'd4,
        OP_REMOVE_VAL = 4'd5,
        OP_FIND       = 4'd6,
        OP_LOWER_BND  = 4'd7,
        OP_MAX        = 4'd8,
        OP_MIN        = 4'd9,
        OP_SORT       = 4'd10
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_OVERFLOW = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_BADPOS   = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_BS_RD,
        S_BS_CHK,
        S_SHUP_RD,
        S_SHUP_WR,
        S_INS_WR,
        S_SHDN_RD,
        S_SHDN_WR,
        S_SORT_RDA,
        S_SORT_RDB,
        S_SORT_CHK,
        S_SORT_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [31:0]     result_value;
        logic [CntW-1:0] result_index;
        logic [2:0]      status;
        logic [CntW-1:0] element_count;
    } result_t;

    // signed order via flipped sign bit
    function automatic logic less_than(input logic [31:0] a, input logic [31:0] b);
        return {~a[31], a[30:0]} < {~b[31], b[30:0]};
    endfunction

endpackage

@@ src/bate_if.sv @@
interface bate_op_if;
    logic        valid;
    logic        ready;
    logic [3:0]  op;
    logic [31:0] value;
    logic [5:0]  position;
    modport source (output valid, op, value, position, input ready);
    modport sink   (input valid, op, value, position, output ready);
endinterface

interface bate_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_value;
    logic [6:0]  result_index;
    logic [2:0]  status;
    logic [6:0]  element_count;
    modport source (output valid, result_value, result_index, status, element_count,
                    input ready);
    modport sink   (input valid, result_value, result_index, status, element_count,
                    output ready);
endinterface

interface bate_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ src/bate_ram.sv @@
module bate_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ src/bate_ctrl.sv @@
module bate_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [3:0]                    op,
    input  logic [31:0]                   value,
    input  logic [5:0]                    position,
    input  logic [6:0]                    capacity,
    input  logic [31:0]                   rdata,
    output logic                          we,
    output logic [bate_pkg::AddrW-1:0]    waddr,
    output logic [31:0]                   wdata,
    output logic [bate_pkg::AddrW-1:0]    raddr,
    output logic                          idle,
    output logic                          done,
    output bate_pkg::result_t             res
);
    localparam int AW = bate_pkg::AddrW;
    localparam int CW = bate_pkg::CntW;

    bate_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [3:0]    op_reg, op_next;
    logic [31:0]   val_reg, val_next;
    logic [5:0]    pos_reg, pos_next;
    logic [CW-1:0] i_reg, i_next;       // walking index
    logic [CW-1:0] lo_reg, lo_next;     // search low bound (+1 offset)
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] lim_reg, lim_next;   // sort pass limit
    logic          swp_reg, swp_next;
    logic [31:0]   acc_reg, acc_next;   // max/min, removed element or sort element a
    logic [31:0]   rv_reg, rv_next;
    logic [CW-1:0] ri_reg, ri_next;
    logic [2:0]    st_reg, st_next;
    logic [CW-1:0] room;
    logic          full;
    logic [CW-1:0] mid;

    assign room = (capacity > CW'(bate_pkg::Depth)) ? CW'(bate_pkg::Depth) : capacity;
    assign full = count_reg >= room;
    assign mid  = CW'(({1'b0, lo_reg} + {1'b0, hi_reg} - 1'b1) >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bate_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        val_reg <= val_next;
        pos_reg <= pos_next;
        i_reg   <= i_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        lim_reg <= lim_next;
        swp_reg <= swp_next;
        acc_reg <= acc_next;
        rv_reg  <= rv_next;
        ri_reg  <= ri_next;
        st_reg  <= st_next;
    end

    // next state and datapath
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        op_next = op_reg; val_next = val_reg; pos_next = pos_reg;
        i_next = i_reg; lo_next = lo_reg; hi_next = hi_reg; lim_next = lim_reg;
        swp_next = swp_reg; acc_next = acc_reg;
        rv_next = rv_reg; ri_next = ri_reg; st_next = st_reg;
        unique case (state_reg)
            bate_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op_next = op; val_next = value; pos_next = position;
                    rv_next = '0; ri_next = '0; st_next = bate_pkg::ST_OK;
                    state_next = bate_pkg::S_DISPATCH;
                end
            end
            bate_pkg::S_DISPATCH:
            begin
                state_next = bate_pkg::S_DONE;
                i_next = '0;
                unique case (op_reg)
                    bate_pkg::OP_APPEND, bate_pkg::OP_PREPEND:
                    begin
                        if (full)
                        begin
                            st_next = bate_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            ri_next = (op_reg == bate_pkg::OP_APPEND) ? count_reg : '0;
                            i_next = count_reg;
                            state_next = bate_pkg::S_SHUP_RD;
                        end
                    end
                    bate_pkg::OP_SORTED_INS, bate_pkg::OP_LOWER_BND:
                    begin
                        if (op_reg == bate_pkg::OP_SORTED_INS && full)
                        begin
                            st_next = bate_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            lo_next = '0; hi_next = count_reg;
                            state_next = bate_pkg::S_BS_RD;
                        end
                    end
                    bate_pkg::OP_APPEND_UNQ, bate_pkg::OP_REMOVE_VAL, bate_pkg::OP_FIND,
                    bate_pkg::OP_MAX, bate_pkg::OP_MIN:
                    begin
                        if (count_reg == '0)
                        begin
                            if (op_reg == bate_pkg::OP_MAX || op_reg == bate_pkg::OP_MIN)
                                st_next = bate_pkg::ST_EMPTY;
                            else if (op_reg == bate_pkg::OP_APPEND_UNQ)
                            begin
                                if (full) st_next = bate_pkg::ST_OVERFLOW;
                                else state_next = bate_pkg::S_INS_WR;
                            end
                            else
                                st_next = bate_pkg::ST_NOTFOUND;
                        end
                        else
                            state_next = bate_pkg::S_SCAN_RD;
                    end
                    bate_pkg::OP_REMOVE_AT:
                    begin
                        if (count_reg == '0)
                            st_next = bate_pkg::ST_EMPTY;
                        else if (CW'(pos_reg) >= count_reg)
                            st_next = bate_pkg::ST_BADPOS;
                        else
                        begin
                            ri_next = CW'(pos_reg);
                            i_next = CW'(pos_reg);
                            state_next = bate_pkg::S_SHDN_RD;
                        end
                    end
                    bate_pkg::OP_SORT:
                    begin
                        if (count_reg > CW'(1))
                        begin
                            lim_next = count_reg;
                            swp_next = 1'b0;
                            state_next = bate_pkg::S_SORT_RDA;
                        end
                    end
                    default: ;
                endcase
            end
            bate_pkg::S_SCAN_RD: state_next = bate_pkg::S_SCAN_CHK;
            bate_pkg::S_SCAN_CHK:
            begin
                state_next = bate_pkg::S_SCAN_RD;
                i_next = i_reg + 1'b1;
                if (op_reg == bate_pkg::OP_MAX || op_reg == bate_pkg::OP_MIN)
                begin
                    if (i_reg == '0 ||
                        (op_reg == bate_pkg::OP_MAX ? bate_pkg::less_than(acc_reg, rdata)
                                                    : bate_pkg::less_than(rdata, acc_reg)))
                        acc_next = rdata;
                    if (i_reg + 1'b1 == count_reg)
                    begin
                        rv_next = (i_reg == '0 ||
                            (op_reg == bate_pkg::OP_MAX ? bate_pkg::less_than(acc_reg, rdata)
                                                        : bate_pkg::less_than(rdata, acc_reg)))
                            ? rdata : acc_reg;
                        state_next = bate_pkg::S_DONE;
                    end
                end
                else if (rdata == val_reg)
                begin
                    ri_next = i_reg;
                    if (op_reg == bate_pkg::OP_REMOVE_VAL)
                    begin
                        // hold the matched element as the removed one
                        acc_next = rdata;
                        i_next = i_reg;
                        state_next = bate_pkg::S_SHDN_RD;
                    end
                    else
                        state_next = bate_pkg::S_DONE;
                end
                else if (i_reg + 1'b1 == count_reg)
                begin
                    state_next = bate_pkg::S_DONE;
                    if (op_reg != bate_pkg::OP_APPEND_UNQ)
                        st_next = bate_pkg::ST_NOTFOUND;
                    else if (full)
                        st_next = bate_pkg::ST_OVERFLOW;
                    else
                        state_next = bate_pkg::S_INS_WR;
                end
            end
            bate_pkg::S_BS_RD:
            begin
                if (lo_reg == hi_reg)
                begin
                    ri_next = hi_reg;
                    if (op_reg == bate_pkg::OP_SORTED_INS)
                    begin
                        i_next = count_reg;
                        state_next = bate_pkg::S_SHUP_RD;
                    end
                    else
                        state_next = bate_pkg::S_DONE;
                end
                else
                    state_next = bate_pkg::S_BS_CHK;
            end
            bate_pkg::S_BS_CHK:
            begin
                if (bate_pkg::less_than(rdata, val_reg))
                    lo_next = mid + 1'b1;
                else
                    hi_next = mid;
                state_next = bate_pkg::S_BS_RD;
            end
            bate_pkg::S_SHUP_RD:
            begin
                // element i-1 moves to i, down to the insert point
                if (i_reg == ri_reg)
                    state_next = bate_pkg::S_INS_WR;
                else
                    state_next = bate_pkg::S_SHUP_WR;
            end
            bate_pkg::S_SHUP_WR:
            begin
                i_next = i_reg - 1'b1;
                state_next = bate_pkg::S_SHUP_RD;
            end
            bate_pkg::S_INS_WR:
            begin
                if (op_reg == bate_pkg::OP_APPEND_UNQ) ri_next = count_reg;
                count_next = count_reg + 1'b1;
                state_next = bate_pkg::S_DONE;
            end
            bate_pkg::S_SHDN_RD:
            begin
                if (i_reg + 1'b1 >= count_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = bate_pkg::S_DONE;
                end
                else
                    state_next = bate_pkg::S_SHDN_WR;
            end
            bate_pkg::S_SHDN_WR:
            begin
                i_next = i_reg + 1'b1;
                state_next = bate_pkg::S_SHDN_RD;
            end
            bate_pkg::S_SORT_RDA: state_next = bate_pkg::S_SORT_RDB;
            bate_pkg::S_SORT_RDB:
            begin
                acc_next = rdata;
                state_next = bate_pkg::S_SORT_CHK;
            end
            bate_pkg::S_SORT_CHK:
            begin
                if (bate_pkg::less_than(rdata, acc_reg))
                begin
                    swp_next = 1'b1;
                    state_next = bate_pkg::S_SORT_WR;
                end
                else if (i_reg + CW'(2) < lim_reg)
                begin
                    i_next = i_reg + 1'b1;
                    acc_next = rdata;
                    state_next = bate_pkg::S_SORT_CHK;
                end
                else if (swp_reg && lim_reg > CW'(2))
                begin
                    i_next = '0; swp_next = 1'b0; lim_next = lim_reg - 1'b1;
                    state_next = bate_pkg::S_SORT_RDA;
                end
                else
                    state_next = bate_pkg::S_DONE;
            end
            bate_pkg::S_SORT_WR:
            begin
                // second write of the swap; a keeps the larger value
                if (i_reg + CW'(2) < lim_reg)
                begin
                    i_next = i_reg + 1'b1;
                    state_next = bate_pkg::S_SORT_CHK;
                end
                else if (lim_reg > CW'(2))
                begin
                    i_next = '0; swp_next = 1'b0; lim_next = lim_reg - 1'b1;
                    state_next = bate_pkg::S_SORT_RDA;
                end
                else
                    state_next = bate_pkg::S_DONE;
            end
            bate_pkg::S_DONE:
            begin
                if (op_reg == bate_pkg::OP_REMOVE_AT || op_reg == bate_pkg::OP_REMOVE_VAL)
                    if (st_reg == bate_pkg::ST_OK) rv_next = acc_reg;
                state_next = bate_pkg::S_IDLE;
            end
            default: state_next = bate_pkg::S_IDLE;
        endcase
        // capture the removed element on the first shift-down read
        if (state_reg == bate_pkg::S_SHDN_RD && i_reg == ri_reg &&
            op_reg == bate_pkg::OP_REMOVE_AT)
            acc_next = rdata;
        if (state_reg == bate_pkg::S_SORT_CHK && bate_pkg::less_than(rdata, acc_reg))
            acc_next = acc_reg;
    end

    // memory access per state
    always_comb
    begin
        we = 1'b0;
        waddr = AW'(i_reg);
        wdata = rdata;
        raddr = AW'(i_reg);
        unique case (state_reg)
            bate_pkg::S_DISPATCH: raddr = pos_reg;
            bate_pkg::S_SCAN_RD, bate_pkg::S_SCAN_CHK:
                raddr = (state_reg == bate_pkg::S_SCAN_CHK) ? AW'(i_reg + 1'b1) : AW'(i_reg);
            bate_pkg::S_BS_RD: raddr = AW'(mid);
            bate_pkg::S_SHUP_RD: raddr = AW'(i_reg - 1'b1);
            bate_pkg::S_SHUP_WR:
            begin
                we = 1'b1; waddr = AW'(i_reg); wdata = rdata;
            end
            bate_pkg::S_INS_WR:
            begin
                we = 1'b1;
                waddr = (op_reg == bate_pkg::OP_APPEND_UNQ) ? AW'(count_reg) : AW'(ri_reg);
                wdata = val_reg;
            end
            bate_pkg::S_SHDN_RD: raddr = AW'(i_reg + 1'b1);
            bate_pkg::S_SHDN_WR:
            begin
                if (i_reg + 1'b1 < count_reg)
                begin
                    we = 1'b1; waddr = AW'(i_reg); wdata = rdata;
                end
            end
            bate_pkg::S_SORT_RDA: raddr = '0;
            bate_pkg::S_SORT_RDB: raddr = AW'(1);
            bate_pkg::S_SORT_CHK:
            begin
                raddr = AW'(i_reg + CW'(2));
                if (bate_pkg::less_than(rdata, acc_reg))
                begin
                    we = 1'b1; waddr = AW'(i_reg); wdata = rdata;
                end
            end
            bate_pkg::S_SORT_WR:
            begin
                raddr = AW'(i_reg + CW'(2));
                we = 1'b1; waddr = AW'(i_reg + 1'b1); wdata = acc_reg;
            end
            default: ;
        endcase
    end

    assign idle = state_reg == bate_pkg::S_IDLE;
    assign done = state_reg == bate_pkg::S_DONE;
    always_comb
    begin
        res.result_value  = ((op_reg == bate_pkg::OP_REMOVE_AT ||
                              op_reg == bate_pkg::OP_REMOVE_VAL) && st_reg == bate_pkg::ST_OK)
                            ? acc_reg : rv_reg;
        res.result_index  = ri_reg;
        res.status        = st_reg;
        res.element_count = count_reg;
    end
endmodule

@@ src/bounded_array_table_engine_top.sv @@
// Channel | Dir | Payload
// op_in   | in  | op, value, position
// res_out | out | result_value, result_index, status, element_count
// cfg     | in  | data (capacity)
// One item at a time: a new item is taken only once the last result has left the output register;
// scans read one element per step; sorted inserts do a binary search, then a shift of
// one place per element, and other inserts and removals shift one place per element.
// Sort is a bubble sort through the same RAM port.
// Reset clears the count and sets capacity to 64; the store is not cleared.
// Hold the input while a result sits unread in the output register.
module bounded_array_table_engine_top (
    input logic            clk,
    input logic            rst_n,
    bate_op_if.sink        op_in,
    bate_res_if.source     res_out,
    bate_cfg_if.sink       cfg
);
    logic [6:0]  cap_reg;
    logic        we;
    logic [bate_pkg::AddrW-1:0] waddr, raddr;
    logic [31:0] wdata, rdata;
    logic        idle, done, start;
    bate_pkg::result_t res;
    bate_pkg::result_t out_reg;
    logic        ov_reg;

    // capacity register
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= 7'd64;
        else if (cfg.valid)
            cap_reg <= cfg.data;
    end

    // accept only when idle and the output slot can take the result
    assign op_in.ready = idle && !ov_reg;
    assign start = op_in.valid && op_in.ready;

    bate_ram #(.Width(32), .Depth(bate_pkg::Depth)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    bate_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start),
        .op(op_in.op), .value(op_in.value), .position(op_in.position),
        .capacity(cap_reg), .rdata(rdata),
        .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr),
        .idle(idle), .done(done), .res(res)
    );

    // hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (done)
            ov_reg <= 1'b1;
        else if (res_out.ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done)
            out_reg <= res;
    end

    assign res_out.valid         = ov_reg;
    assign res_out.result_value  = out_reg.result_value;
    assign res_out.result_index  = out_reg.result_index;
    assign res_out.status        = out_reg.status;
    assign res_out.element_count = out_reg.element_count;
endmodule

@@ src/bate_checker.sv @@
module bate_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [6:0]  element_count
);
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= bate_pkg::ST_BADPOS) else $error("bad status");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> element_count <= 7'(bate_pkg::Depth)) else $error("count range");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("double accept");
endmodule

bind bounded_array_table_engine_top bate_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(op_in.valid), .in_ready(op_in.ready),
    .out_valid(res_out.valid), .out_ready(res_out.ready),
    .status(res_out.status), .element_count(res_out.element_count)
);

@@ tb/sv/bounded_array_table_engine_top_test.sv @@
`timescale 1ns / 100ps

module bounded_array_table_engine_top_test;

    typedef struct {
        bate_pkg::op_t op;
        logic [31:0]   value;
        logic [5:0]    position;
    } list_op_t;

    typedef struct {
        logic [31:0]       rvalue;
        logic [6:0]        rindex;
        bate_pkg::status_t status;
        logic [6:0]        count;
    } list_result_t;

    logic clk;
    logic rst_n;

    bate_op_if  op_ch ();
    bate_res_if res_ch ();
    bate_cfg_if cfg_ch ();

    bounded_array_table_engine_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .op_in   (op_ch.sink),
        .res_out (res_ch.source),
        .cfg     (cfg_ch.sink)
    );

    // Shadow copy of the list held by the block
    logic [31:0] shadow_list [64];
    int          shadow_count;
    int          shadow_cap;

    list_op_t     pending_ops [$];
    list_result_t expected_results [$];

    int  error_count;
    int  result_count;
    int  cycle_count;
    int  sort_count;
    int  overflow_count;
    int  hold_off;
    bit  drive_en;
    bit  in_taken;
    int  send_gap;
    int  recv_gap;

    localparam int CycleLimit = 3000000;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Order on signed 32-bit values
    function automatic bit signed_less(logic [31:0] a, logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic int search_lower(logic [31:0] v);
        int lo;
        int hi;
        int mid;
        lo = -1;
        hi = shadow_count;
        while (lo < hi - 1)
        begin
            mid = (lo + hi) / 2;
            if (signed_less(shadow_list[mid], v))
                lo = mid;
            else
                hi = mid;
        end
        return hi;
    endfunction

    function automatic int search_linear(logic [31:0] v);
        for (int i = 0; i < shadow_count; i++)
            if (shadow_list[i] == v)
                return i;
        return shadow_count;
    endfunction

    function automatic void place_at(int p, logic [31:0] v);
        for (int i = shadow_count; i > p; i--)
            shadow_list[i] = shadow_list[i - 1];
        shadow_list[p] = v;
        shadow_count++;
    endfunction

    function automatic logic [31:0] take_at(int p);
        logic [31:0] r;
        r = shadow_list[p];
        for (int i = p + 1; i < shadow_count; i++)
            shadow_list[i - 1] = shadow_list[i];
        shadow_count--;
        return r;
    endfunction

    function automatic bit list_full();
        return shadow_count >= ((shadow_cap > 64) ? 64 : shadow_cap);
    endfunction

    // Apply one operation to the shadow list and return its result
    function automatic list_result_t apply_list_op(list_op_t t);
        list_result_t r;
        int p;
        bit swapped;
        logic [31:0] tmp;
        r.rvalue = '0;
        r.rindex = '0;
        r.status = bate_pkg::ST_OK;
        case (t.op)
            bate_pkg::OP_APPEND, bate_pkg::OP_PREPEND, bate_pkg::OP_SORTED_INS:
            begin
                if (list_full())
                    r.status = bate_pkg::ST_OVERFLOW;
                else
                begin
                    p = (t.op == bate_pkg::OP_APPEND) ? shadow_count :
                        (t.op == bate_pkg::OP_PREPEND) ? 0 : search_lower(t.value);
                    place_at(p, t.value);
                    r.rindex = 7'(p);
                end
            end
            bate_pkg::OP_APPEND_UNQ:
            begin
                p = search_linear(t.value);
                if (p < shadow_count)
                    r.rindex = 7'(p);
                else if (list_full())
                    r.status = bate_pkg::ST_OVERFLOW;
                else
                begin
                    r.rindex = 7'(shadow_count);
                    place_at(shadow_count, t.value);
                end
            end
            bate_pkg::OP_REMOVE_AT:
            begin
                if (shadow_count == 0)
                    r.status = bate_pkg::ST_EMPTY;
                else if (t.position >= shadow_count)
                    r.status = bate_pkg::ST_BADPOS;
                else
                begin
                    r.rvalue = take_at(t.position);
                    r.rindex = 7'(t.position);
                end
            end
            bate_pkg::OP_REMOVE_VAL, bate_pkg::OP_FIND:
            begin
                p = search_linear(t.value);
                if (p >= shadow_count)
                    r.status = bate_pkg::ST_NOTFOUND;
                else
                begin
                    r.rindex = 7'(p);
                    if (t.op == bate_pkg::OP_REMOVE_VAL)
                        r.rvalue = take_at(p);
                end
            end
            bate_pkg::OP_LOWER_BND:
                r.rindex = 7'(search_lower(t.value));
            bate_pkg::OP_MAX, bate_pkg::OP_MIN:
            begin
                if (shadow_count == 0)
                    r.status = bate_pkg::ST_EMPTY;
                else
                begin
                    r.rvalue = shadow_list[0];
                    for (int i = 1; i < shadow_count; i++)
                        if (t.op == bate_pkg::OP_MAX ? signed_less(r.rvalue, shadow_list[i])
                                                     : signed_less(shadow_list[i], r.rvalue))
                            r.rvalue = shadow_list[i];
                end
            end
            bate_pkg::OP_SORT:
            begin
                swapped = 1'b1;
                for (int i = shadow_count; i > 1 && swapped; i--)
                begin
                    swapped = 1'b0;
                    for (int j = 0; j + 1 < i; j++)
                        if (signed_less(shadow_list[j + 1], shadow_list[j]))
                        begin
                            tmp = shadow_list[j];
                            shadow_list[j] = shadow_list[j + 1];
                            shadow_list[j + 1] = tmp;
                            swapped = 1'b1;
                        end
                end
            end
            default: ;
        endcase
        r.count = 7'(shadow_count);
        return r;
    endfunction

    // Pick a value: extremes, a small pool that makes matches likely, or anything
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2, 3: return $urandom;
            default: return $urandom_range(0, 15) - 8;
        endcase
    endfunction

    function automatic list_op_t make_op(bate_pkg::op_t o, logic [31:0] v, int p);
        list_op_t t;
        t.op = o;
        t.value = v;
        t.position = 6'(p);
        return t;
    endfunction

    // Random gap: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Driver: present queued items on the falling edge, with random gaps
    always @(negedge clk)
    begin
        if (!rst_n || !drive_en)
        begin
            op_ch.valid <= 1'b0;
            in_taken <= 1'b0;
        end
        else if (op_ch.valid && !in_taken)
        begin
            // hold the item until taken
        end
        else if (send_gap > 0)
        begin
            op_ch.valid <= 1'b0;
            in_taken <= 1'b0;
            send_gap <= send_gap - 1;
        end
        else if (pending_ops.size() > 0)
        begin
            op_ch.valid    <= 1'b1;
            op_ch.op       <= pending_ops[0].op;
            op_ch.value    <= pending_ops[0].value;
            op_ch.position <= pending_ops[0].position;
            void'(pending_ops.pop_front());
            in_taken <= 1'b0;
            send_gap <= pick_gap();
        end
        else
        begin
            op_ch.valid <= 1'b0;
            in_taken <= 1'b0;
        end
    end

    // Receiver readiness: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            res_ch.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else if (recv_gap > 0)
        begin
            res_ch.ready <= 1'b0;
            recv_gap <= recv_gap - 1;
        end
        else
        begin
            res_ch.ready <= 1'b1;
            recv_gap <= pick_gap();
        end
    end

    // Predict on acceptance of an item
    always @(posedge clk)
    begin
        if (rst_n && op_ch.valid && op_ch.ready)
        begin
            list_op_t t;
            t.op = bate_pkg::op_t'(op_ch.op);
            t.value = op_ch.value;
            t.position = op_ch.position;
            in_taken <= 1'b1;
            expected_results.push_back(apply_list_op(t));
            if (t.op == bate_pkg::OP_SORT)
                sort_count++;
            if (expected_results[$].status == bate_pkg::ST_OVERFLOW)
                overflow_count++;
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            list_result_t e;
            result_count++;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result item");
                error_count++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (res_ch.result_value !== e.rvalue)
                begin
                    $error("result_value: expected %h, got %h", e.rvalue, res_ch.result_value);
                    error_count++;
                end
                if (res_ch.result_index !== e.rindex)
                begin
                    $error("result_index: expected %0d, got %0d", e.rindex,
                           res_ch.result_index);
                    error_count++;
                end
                if (res_ch.status !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, res_ch.status);
                    error_count++;
                end
                if (res_ch.element_count !== e.count)
                begin
                    $error("element_count: expected %0d, got %0d", e.count,
                           res_ch.element_count);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run if it hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // Wait until every queued item is taken and every result is back
    task automatic drain();
        while (pending_ops.size() > 0 || op_ch.valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Write capacity while the block is idle
    task automatic set_capacity(int cap);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= cap[6:0];
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        shadow_cap = cap;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Queue a burst of random operations, undefined op codes included; random content
    task automatic queue_random_burst(int n);
        bate_pkg::op_t o;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2: o = bate_pkg::OP_APPEND;
                3:       o = bate_pkg::OP_PREPEND;
                4, 5, 6: o = bate_pkg::OP_SORTED_INS;
                7, 8:    o = bate_pkg::OP_APPEND_UNQ;
                9, 10:   o = bate_pkg::OP_REMOVE_AT;
                11, 12:  o = bate_pkg::OP_REMOVE_VAL;
                13:      o = bate_pkg::OP_FIND;
                14:      o = bate_pkg::OP_LOWER_BND;
                15:      o = bate_pkg::OP_MAX;
                16:      o = bate_pkg::OP_MIN;
                17:      o = ($urandom_range(0, 3) == 0) ? bate_pkg::OP_SORT : bate_pkg::OP_FIND;
                18:      o = bate_pkg::op_t'($urandom_range(11, 15));
                default: o = bate_pkg::op_t'($urandom_range(0, 15));
            endcase
            pending_ops.push_back(make_op(o, pick_value(), int'($urandom_range(0, 63))));
        end
    endtask

    initial
    begin
        int caps [6];
        rst_n        = 1'b0;
        drive_en     = 1'b0;
        error_count  = 0;
        result_count = 0;
        cycle_count  = 0;
        sort_count   = 0;
        overflow_count = 0;
        hold_off     = 0;
        send_gap     = 0;
        recv_gap     = 0;
        shadow_count = 0;
        shadow_cap   = 64;
        op_ch.valid  = 1'b0;
        op_ch.op     = bate_pkg::OP_APPEND;
        op_ch.value  = '0;
        op_ch.position = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        drive_en = 1'b1;

        // Directed: empty-list cases, extremes, every op, capacity edge
        set_capacity(3);
        pending_ops.push_back(make_op(bate_pkg::OP_REMOVE_AT, 0, 0));
        pending_ops.push_back(make_op(bate_pkg::OP_REMOVE_VAL, 5, 0));
        pending_ops.push_back(make_op(bate_pkg::OP_FIND, 5, 0));
        pending_ops.push_back(make_op(bate_pkg::OP_LOWER_BND, 7, 0));
        pending_ops.push_back(make_op(bate_pkg::OP_MAX, 0, 0));
        pending_ops.push_back(make_op(bate_pkg::OP_MIN, 0, 0));
        pending_ops.push_back(make_op(bate_pkg::OP_SORT, 0, 0));
        pending_ops.push_back(make_op(bate_pkg::OP_SORTED_INS, 32'h7fff_ffff, 0));
        pending_ops.push_back(make_op(bate_pkg::OP_SORTED_INS, 32'h8000_0000, 0));
        pending_ops.push_back(make_op(bate_pkg::OP_PREPEND, 32'hffff_ffff, 0));
        pending_ops.push_back(make_op(bate_pkg::OP_APPEND, 1, 0));
        pending_ops.push_back(make_op(bate_pkg::OP_APPEND_UNQ, 32'hffff_ffff, 0));
        pending_ops.push_back(make_op(bate_pkg::OP_APPEND_UNQ, 9, 0));
        pending_ops.push_back(make_op(bate_pkg::OP_REMOVE_AT, 0, 63));
        pending_ops.push_back(make_op(bate_pkg::OP_LOWER_BND, 0, 0));
        pending_ops.push_back(make_op(bate_pkg::OP_MAX, 0, 0));
        pending_ops.push_back(make_op(bate_pkg::OP_MIN, 0, 0));
        pending_ops.push_back(make_op(bate_pkg::OP_FIND, 32'h8000_0000, 0));
        pending_ops.push_back(make_op(bate_pkg::op_t'(4'd15), 0, 0));
        pending_ops.push_back(make_op(bate_pkg::OP_REMOVE_VAL, 32'h7fff_ffff, 0));
        pending_ops.push_back(make_op(bate_pkg::OP_SORT, 0, 0));
        pending_ops.push_back(make_op(bate_pkg::OP_REMOVE_AT, 0, 1));
        drain();

        // Lower capacity to the count: inserts overflow, data kept
        set_capacity(1);
        pending_ops.push_back(make_op(bate_pkg::OP_APPEND, 3, 0));
        pending_ops.push_back(make_op(bate_pkg::OP_APPEND_UNQ, 4, 0));
        drain();

        // Random phases across capacity settings, extremes included
        caps = '{64, 127, 1, 0, 8, 100};
        foreach (caps[k])
        begin
            set_capacity(caps[k]);
            if (k == 1)
                hold_off = 400;  // receiver blocks while the sender keeps offering
            queue_random_burst(k == 0 || k == 5 ? 90 : 40);
            drain();
            // empty the list so later phases start from an empty list
            repeat (shadow_count)
                pending_ops.push_back(make_op(bate_pkg::OP_REMOVE_AT, 0, 0));
            drain();
        end

        $display("covered %0d results, %0d sorts, %0d overflows, capacities 0..127",
                 result_count, sort_count, overflow_count);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
